/* design/efg_pkg.sv */
`timescale 1ns / 1ps

package efg_pkg;

    // Defaults for the top-level parameters.
    localparam int FLAG_BITS_DEF   = 32;
    localparam int MAX_WAITERS_DEF = 8;

    // Fixed field widths.
    localparam int THREAD_W = 3;
    localparam int STATUS_W = 3;
    localparam int REQ_W    = 2;
    localparam int MODE_W   = 2;

    // Request kinds.
    localparam logic [REQ_W-1:0] REQ_WAIT     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SEND     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_WITHDRAW = 2'd2;

    // Wait modes.
    localparam logic [MODE_W-1:0] MODE_ANY = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ALL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ONE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RSV = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_GRANTED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TRY_AGAIN = 3'd1;
    localparam logic [STATUS_W-1:0] ST_QUEUED    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_WITHDRAWN = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SEND_DONE = 3'd4;

    // Fixed-width part of one waiter entry.
    typedef struct packed {
        logic [THREAD_W-1:0] thread;
        logic [MODE_W-1:0]   mode;
        logic                clr;
    } meta_t;

    // Per-cell control: shift takes the right neighbor, load takes the load entry.
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

/* design/efg_cell.sv */
`timescale 1ns / 1ps

module efg_cell #(
    parameter int FLAG_BITS = efg_pkg::FLAG_BITS_DEF
) (
    input  logic                   aclk,
    input  efg_pkg::cell_ctrl_t    ctrl,
    input  efg_pkg::meta_t         load_meta,
    input  logic [FLAG_BITS-1:0]   load_wanted,
    input  efg_pkg::meta_t         right_meta,
    input  logic [FLAG_BITS-1:0]   right_wanted,
    output efg_pkg::meta_t         cur_meta,
    output logic [FLAG_BITS-1:0]   cur_wanted
);

    efg_pkg::meta_t         meta_reg;
    efg_pkg::meta_t         meta_next;
    logic [FLAG_BITS-1:0]   wanted_reg;
    logic [FLAG_BITS-1:0]   wanted_next;

    // A load wins over a shift; a shift takes the entry from the right neighbor.
    always_comb begin
        meta_next   = meta_reg;
        wanted_next = wanted_reg;
        if (ctrl.load) begin
            meta_next   = load_meta;
            wanted_next = load_wanted;
        end else if (ctrl.shift) begin
            meta_next   = right_meta;
            wanted_next = right_wanted;
        end
    end

    // Entry storage holds payload only and needs no reset.
    always_ff @(posedge aclk) begin
        meta_reg   <= meta_next;
        wanted_reg <= wanted_next;
    end

    assign cur_meta   = meta_reg;
    assign cur_wanted = wanted_reg;

endmodule

/* design/event_flag_group_engine.sv */
`timescale 1ns / 1ps

// Event flag group engine.
// Requests enter on the s_ stream: s_tuser carries the request kind (wait, send,
// withdraw) and s_tdata the thread, flag bits, mask bits and wait options.
// Results leave on the m_ stream: m_tuser carries the status, m_tdata the thread
// and granted bits, and m_tlast marks the final result of a request.
// The exclusive mask is written through the APB port at byte address 0.
// A wait is decided in the cycle it is accepted; its single result is visible in
// the next cycle, and a new request can follow at once while results drain.
// A send or a withdraw rotates the waiter list through the head cell of the chain,
// one waiter per cycle while the output register can take a transaction, in
// order: accept, one visit per waiter, final result; a send gives one result for
// each woken waiter plus a send-done result.
// The rotation advances only while the output register can take a new
// transaction, so a stalled receiver freezes the walk and nothing is lost.
// Reset clears the flag word, the waiter count, the exclusive mask and the
// output valid; the waiter cells themselves are not cleared.
module event_flag_group_engine #(
    parameter int FLAG_BITS   = efg_pkg::FLAG_BITS_DEF,
    parameter int MAX_WAITERS = efg_pkg::MAX_WAITERS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // s_tdata: thread_id, flag_bits, mask_bits, wait_mode, clear_on_exit, no_wait
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [((2*FLAG_BITS+7+7)/8)*8-1:0] s_tdata,
    // s_tuser: req_type
    input  logic [efg_pkg::REQ_W-1:0]    s_tuser,
    // m_tdata: target_thread, granted_flags
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [((FLAG_BITS+3+7)/8)*8-1:0] m_tdata,
    // m_tuser: status
    output logic [efg_pkg::STATUS_W-1:0] m_tuser,
    output logic                         m_tlast,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int F      = FLAG_BITS;
    localparam int TW     = efg_pkg::THREAD_W;
    localparam int OUT_W  = ((F + TW + 7) / 8) * 8;
    localparam int IW     = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int CW     = $clog2(MAX_WAITERS + 1);
    localparam int VW     = (F < 32) ? F : 32;
    localparam logic [F-1:0] VMASK = {F{1'b1}} >> (F - VW);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    // Bits of avail that satisfy a condition on wanted, or zero.
    function automatic logic [F-1:0] flag_match(input logic [F-1:0] avail,
                                                input logic [F-1:0] wanted,
                                                input logic [efg_pkg::MODE_W-1:0] mode);
        logic [F-1:0] r;
        logic [F-1:0] s;
        r = avail & wanted;
        s = r;
        if (mode == efg_pkg::MODE_ALL && r != wanted) begin
            r = '0;
        end
        if (mode == efg_pkg::MODE_ONE) begin
            for (int k = 1; k < F; k = k * 2) begin
                s = s | (s >> k);
            end
            r = s & ~(s >> 1);
        end
        return r;
    endfunction

    // Registers.
    logic [1:0]                   state_reg, state_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [CW-1:0]                steps_reg, steps_next;
    logic [F-1:0]                 flag_reg, flag_next;
    logic [F-1:0]                 given_reg, given_next;
    logic [F-1:0]                 acc_reg, acc_next;
    logic                         op_send_reg, op_send_next;
    logic [TW-1:0]                thr_reg, thr_next;
    logic                         found_reg, found_next;
    logic [31:0]                  excl_reg, excl_next;
    logic                         out_valid_reg, out_valid_next;
    logic [TW-1:0]                out_thread_reg, out_thread_next;
    logic [efg_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [F-1:0]                 out_granted_reg, out_granted_next;
    logic                         out_last_reg, out_last_next;

    // Input fields.
    logic [efg_pkg::REQ_W-1:0]    in_req;
    logic [TW-1:0]                in_thread;
    logic [F-1:0]                 in_flag;
    logic [F-1:0]                 in_mask;
    logic [efg_pkg::MODE_W-1:0]   in_mode_raw;
    logic [efg_pkg::MODE_W-1:0]   in_mode;
    logic                         in_clr;
    logic                         in_nowait;

    assign in_req      = s_tuser;
    assign in_thread   = s_tdata[TW-1:0];
    assign in_flag     = s_tdata[TW +: F] & VMASK;
    assign in_mask     = s_tdata[TW+F +: F] & VMASK;
    assign in_mode_raw = s_tdata[TW+2*F +: efg_pkg::MODE_W];
    assign in_clr      = s_tdata[TW+2*F+2];
    assign in_nowait   = s_tdata[TW+2*F+3];
    assign in_mode     = (in_mode_raw == efg_pkg::MODE_RSV) ? efg_pkg::MODE_ANY : in_mode_raw;

    // Configuration port.
    logic cfg_wr;
    logic [F-1:0] excl_f;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == 1'b0) ? excl_reg : 32'd0;
    assign excl_next = (cfg_wr && paddr[2] == 1'b0) ? pwdata : excl_reg;
    assign excl_f = F'(excl_reg[VW-1:0]);

    // Chain of waiter cells.
    efg_pkg::meta_t       meta_w   [MAX_WAITERS];
    logic [F-1:0]         wanted_w [MAX_WAITERS];
    logic                 load_en;
    logic [IW-1:0]        load_idx;
    efg_pkg::meta_t       load_meta;
    logic [F-1:0]         load_wanted;
    logic                 walk_step;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_WAITERS; gi++) begin : g_cell
            efg_pkg::cell_ctrl_t cctrl;
            efg_pkg::meta_t      rmeta;
            logic [F-1:0]        rwanted;

            assign cctrl.shift = walk_step;
            assign cctrl.load  = load_en && (load_idx == IW'(gi));

            if (gi < MAX_WAITERS - 1) begin : g_mid
                assign rmeta   = meta_w[gi+1];
                assign rwanted = wanted_w[gi+1];
            end else begin : g_end
                assign rmeta   = meta_w[gi];
                assign rwanted = wanted_w[gi];
            end

            efg_cell #(
                .FLAG_BITS(F)
            ) u_cell (
                .aclk        (aclk),
                .ctrl        (cctrl),
                .load_meta   (load_meta),
                .load_wanted (load_wanted),
                .right_meta  (rmeta),
                .right_wanted(rwanted),
                .cur_meta    (meta_w[gi]),
                .cur_wanted  (wanted_w[gi])
            );
        end
    endgenerate

    // Handshake and walk decisions.
    logic          adv;
    logic          acc_in;
    logic          full;
    logic [CW-1:0] cnt_dec;
    logic [F-1:0]  wait_r;
    logic [F-1:0]  walk_r;
    logic          hit;
    efg_pkg::meta_t head_meta;
    efg_pkg::meta_t in_meta;

    assign adv       = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && adv;
    assign acc_in    = s_tvalid && s_tready;
    assign walk_step = (state_reg == S_WALK) && adv;
    assign full      = (count_reg == CW'(MAX_WAITERS));
    assign cnt_dec   = count_reg - CW'(1);
    assign head_meta = meta_w[0];
    assign wait_r    = flag_match(flag_reg, in_flag, in_mode);
    assign walk_r    = flag_match(flag_reg & ~given_reg, wanted_w[0], head_meta.mode);
    assign hit       = op_send_reg ? (walk_r != '0)
                                   : (!found_reg && head_meta.thread == thr_reg);

    assign in_meta.thread = in_thread;
    assign in_meta.mode   = in_mode;
    assign in_meta.clr    = in_clr;

    // Next-state logic of the controller.
    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        steps_next       = steps_reg;
        flag_next        = flag_reg;
        given_next       = given_reg;
        acc_next         = acc_reg;
        op_send_next     = op_send_reg;
        thr_next         = thr_reg;
        found_next       = found_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_thread_next  = out_thread_reg;
        out_status_next  = out_status_reg;
        out_granted_next = out_granted_reg;
        out_last_next    = out_last_reg;
        load_en          = 1'b0;
        load_idx         = count_reg[IW-1:0];
        load_meta        = in_meta;
        load_wanted      = in_flag;

        case (state_reg)
            S_IDLE: begin
                if (acc_in) begin
                    case (in_req)
                        efg_pkg::REQ_WAIT: begin
                            out_valid_next   = 1'b1;
                            out_thread_next  = in_thread;
                            out_last_next    = 1'b1;
                            out_granted_next = '0;
                            if (wait_r != '0) begin
                                out_status_next  = efg_pkg::ST_GRANTED;
                                out_granted_next = wait_r;
                                flag_next = flag_reg & ~(wait_r & excl_f)
                                            & ~(in_clr ? wait_r : '0);
                            end else if (in_nowait || full) begin
                                out_status_next = efg_pkg::ST_TRY_AGAIN;
                            end else begin
                                out_status_next = efg_pkg::ST_QUEUED;
                                load_en         = 1'b1;
                                count_next      = count_reg + CW'(1);
                            end
                        end
                        efg_pkg::REQ_SEND: begin
                            flag_next    = flag_reg ^ ((flag_reg ^ in_flag) & in_mask);
                            given_next   = '0;
                            acc_next     = '0;
                            op_send_next = 1'b1;
                            steps_next   = count_reg;
                            state_next   = (count_reg == '0) ? S_DONE : S_WALK;
                        end
                        efg_pkg::REQ_WITHDRAW: begin
                            op_send_next = 1'b0;
                            thr_next     = in_thread;
                            found_next   = 1'b0;
                            steps_next   = count_reg;
                            state_next   = (count_reg == '0) ? S_DONE : S_WALK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (adv) begin
                    steps_next = steps_reg - CW'(1);
                    if (steps_reg == CW'(1)) begin
                        state_next = S_DONE;
                    end
                    if (hit) begin
                        // The head leaves the list; the rest move up one cell.
                        count_next = cnt_dec;
                        if (op_send_reg) begin
                            out_valid_next   = 1'b1;
                            out_thread_next  = head_meta.thread;
                            out_status_next  = efg_pkg::ST_GRANTED;
                            out_granted_next = walk_r;
                            out_last_next    = 1'b0;
                            acc_next   = acc_reg | (walk_r & excl_f)
                                         | (head_meta.clr ? walk_r : '0);
                            given_next = given_reg | (walk_r & excl_f);
                        end else begin
                            found_next = 1'b1;
                        end
                    end else begin
                        // The head goes back in at the tail, keeping list order.
                        load_en     = 1'b1;
                        load_idx    = cnt_dec[IW-1:0];
                        load_meta   = head_meta;
                        load_wanted = wanted_w[0];
                    end
                end
            end
            S_DONE: begin
                if (adv) begin
                    out_valid_next   = 1'b1;
                    out_last_next    = 1'b1;
                    out_granted_next = '0;
                    if (op_send_reg) begin
                        out_thread_next = '0;
                        out_status_next = efg_pkg::ST_SEND_DONE;
                        flag_next       = flag_reg & ~acc_reg;
                    end else begin
                        out_thread_next = thr_reg;
                        out_status_next = found_reg ? efg_pkg::ST_WITHDRAWN
                                                    : efg_pkg::ST_TRY_AGAIN;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            flag_reg      <= '0;
            excl_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            flag_reg      <= flag_next;
            excl_reg      <= excl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Walk bookkeeping and output payload.
    always_ff @(posedge aclk) begin
        steps_reg       <= steps_next;
        given_reg       <= given_next;
        acc_reg         <= acc_next;
        op_send_reg     <= op_send_next;
        thr_reg         <= thr_next;
        found_reg       <= found_next;
        out_thread_reg  <= out_thread_next;
        out_status_reg  <= out_status_next;
        out_granted_reg <= out_granted_next;
        out_last_reg    <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_granted_reg, out_thread_reg});
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    // The waiter count never exceeds the number of cells.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_WAITERS))
        else $error("waiter count beyond chain length");

    // A walk always has waiters left to visit.
    a_walk_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WALK |-> steps_reg != '0 && steps_reg <= count_reg)
        else $error("walk without remaining waiters");

    // The list never grows during a walk.
    a_walk_shrink: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WALK |=> count_reg <= $past(count_reg))
        else $error("waiter list grew during walk");

    // Only grants of a send come without tlast.
    a_mid_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser == efg_pkg::ST_GRANTED)
        else $error("non-final result that is not a grant");

    // A send-done result carries no thread and no bits.
    a_send_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == efg_pkg::ST_SEND_DONE |-> m_tlast && m_tdata == '0)
        else $error("malformed send-done result");

endmodule
